// ----- rtl/sbrd_pkg.sv -----
// Package for the servo bus response deframer.
// Holds byte/word types, phase, status and kind codes, frame length codes
// and the result record. No dependencies.
package sbrd_pkg;

    typedef logic [7:0]  t_byte;
    typedef logic [15:0] t_word;

    // Default number of parameter bytes kept per frame
    localparam int KEPT_PARAMS_DEF = 4;

    // Reset value of the header byte register
    localparam t_byte HEADER_RESET = 8'd85;

    // Length field codes
    localparam t_byte LEN_MIN  = 8'd3;  // id/len/cmd only, no parameters
    localparam t_byte LEN_BYTE = 8'd4;  // one parameter byte
    localparam t_byte LEN_WORD = 8'd5;  // one little-endian word
    localparam t_byte LEN_PAIR = 8'd7;  // two little-endian words

    // Parser phase
    typedef enum logic [2:0] {
        PH_HDR1  = 3'd0,
        PH_HDR2  = 3'd1,
        PH_ID    = 3'd2,
        PH_LEN   = 3'd3,
        PH_CMD   = 3'd4,
        PH_PARAM = 3'd5,
        PH_SUM   = 3'd6
    } t_phase;

    // Frame status
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_CSUM    = 2'd1,
        ST_BAD_LEN = 2'd2,
        ST_TRUNC   = 2'd3
    } t_status;

    // Decoded value kind
    typedef enum logic [1:0] {
        VK_NONE = 2'd0,
        VK_BYTE = 2'd1,
        VK_WORD = 2'd2,
        VK_PAIR = 2'd3
    } t_kind;

    // One result item
    typedef struct packed {
        t_status status;
        t_byte   unit_id;
        t_byte   command;
        t_byte   frame_length;
        t_kind   kind;
        t_word   first_value;
        t_word   second_value;
    } t_result;

endpackage

// ----- rtl/sbrd_if.sv -----
// Channel interfaces of the servo bus response deframer: byte input,
// result output and header register write. Depends on sbrd_pkg.

// Received byte channel
interface sbrd_in_if;
    logic            valid;
    logic            ready;
    sbrd_pkg::t_byte rx_byte;
    logic            line_idle;

    modport source (output valid, output rx_byte, output line_idle, input ready);
    modport sink   (input valid, input rx_byte, input line_idle, output ready);
endinterface

// Result channel
interface sbrd_out_if;
    logic            valid;
    logic            ready;
    logic [1:0]      frame_status;
    sbrd_pkg::t_byte unit_id;
    sbrd_pkg::t_byte command;
    sbrd_pkg::t_byte frame_length;
    logic [1:0]      value_kind;
    sbrd_pkg::t_word first_value;
    sbrd_pkg::t_word second_value;

    modport source (output valid, output frame_status, output unit_id, output command,
                    output frame_length, output value_kind, output first_value,
                    output second_value, input ready);
    modport sink   (input valid, input frame_status, input unit_id, input command,
                    input frame_length, input value_kind, input first_value,
                    input second_value, output ready);
endinterface

// Header byte register write channel
interface sbrd_cfg_if;
    logic            valid;
    logic            ready;
    sbrd_pkg::t_byte header_byte;

    modport source (output valid, output header_byte, input ready);
    modport sink   (input valid, input header_byte, output ready);
endinterface

// ----- rtl/sbrd_parser.sv -----
// Frame parser: phase machine, running checksum, held header fields and
// parameter store; forms the result for the item being stepped.
// Depends on sbrd_pkg.
module sbrd_parser #(
    parameter int KEPT_PARAMS = sbrd_pkg::KEPT_PARAMS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  sbrd_pkg::t_byte   i_rx_byte,
    input  logic              i_line_idle,
    input  sbrd_pkg::t_byte   i_header_byte,
    output logic              o_emit,
    output sbrd_pkg::t_result o_result
);
    import sbrd_pkg::*;

    localparam int IDX_W = (KEPT_PARAMS > 1) ? $clog2(KEPT_PARAMS) : 1;

    t_phase r_phase, n_phase;
    t_byte  r_sum, n_sum;
    t_byte  r_id, n_id;
    t_byte  r_len, n_len;
    t_byte  r_cmd, n_cmd;
    t_byte  r_seen, n_seen;
    t_byte  r_store [KEPT_PARAMS];

    logic   store_we;
    t_byte  sum_add;
    t_byte  seen_inc;
    logic   params_done;

    assign sum_add     = r_sum + i_rx_byte;
    assign seen_inc    = r_seen + 8'd1;
    // last parameter when params seen (after this one) + 3 reaches length
    assign params_done = ({1'b0, seen_inc} + 9'd3) >= {1'b0, r_len};

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (i_line_idle) begin
            n_phase = PH_HDR1;
        end else begin
            case (r_phase)
                PH_HDR1: begin
                    if (i_rx_byte == i_header_byte) n_phase = PH_HDR2;
                end
                PH_HDR2: begin
                    n_phase = (i_rx_byte == i_header_byte) ? PH_ID : PH_HDR1;
                end
                PH_ID: begin
                    n_phase = PH_LEN;
                end
                PH_LEN: begin
                    n_phase = (i_rx_byte < LEN_MIN) ? PH_HDR1 : PH_CMD;
                end
                PH_CMD: begin
                    n_phase = (r_len > LEN_MIN) ? PH_PARAM : PH_SUM;
                end
                PH_PARAM: begin
                    if (params_done) n_phase = PH_SUM;
                end
                PH_SUM: begin
                    n_phase = PH_HDR1;
                end
                default: begin
                    n_phase = PH_HDR1;
                end
            endcase
        end
    end

    // Held fields, checksum and result
    always_comb begin
        n_sum    = r_sum;
        n_id     = r_id;
        n_len    = r_len;
        n_cmd    = r_cmd;
        n_seen   = r_seen;
        store_we = 1'b0;
        o_emit   = 1'b0;
        o_result = '0;
        o_result.unit_id = r_id;
        if (i_line_idle) begin
            // abort after the header: report what was received so far
            case (r_phase)
                PH_ID, PH_LEN, PH_CMD, PH_PARAM, PH_SUM: begin
                    o_emit          = 1'b1;
                    o_result.status = ST_TRUNC;
                    if (r_phase == PH_PARAM || r_phase == PH_SUM) begin
                        o_result.command = r_cmd;
                    end
                    if (r_phase == PH_CMD || r_phase == PH_PARAM || r_phase == PH_SUM) begin
                        o_result.frame_length = r_len;
                    end
                end
                default: begin
                    o_emit = 1'b0;
                end
            endcase
        end else begin
            case (r_phase)
                PH_ID: begin
                    n_id   = i_rx_byte;
                    n_len  = '0;
                    n_cmd  = '0;
                    n_seen = '0;
                    n_sum  = i_rx_byte;
                end
                PH_LEN: begin
                    n_len = i_rx_byte;
                    if (i_rx_byte < LEN_MIN) begin
                        o_emit                = 1'b1;
                        o_result.status       = ST_BAD_LEN;
                        o_result.frame_length = i_rx_byte;
                    end else begin
                        n_sum = sum_add;
                    end
                end
                PH_CMD: begin
                    n_cmd = i_rx_byte;
                    n_sum = sum_add;
                end
                PH_PARAM: begin
                    store_we = (r_seen < 8'(KEPT_PARAMS));
                    n_sum    = sum_add;
                    n_seen   = seen_inc;
                end
                PH_SUM: begin
                    o_emit                = 1'b1;
                    o_result.command      = r_cmd;
                    o_result.frame_length = r_len;
                    if (~r_sum != i_rx_byte) begin
                        o_result.status = ST_CSUM;
                    end else begin
                        o_result.status = ST_OK;
                        if (r_len == LEN_BYTE) begin
                            o_result.kind        = VK_BYTE;
                            o_result.first_value = {8'd0, r_store[0]};
                        end else if (r_len == LEN_WORD) begin
                            o_result.kind        = VK_WORD;
                            o_result.first_value = {r_store[1], r_store[0]};
                        end else if (r_len == LEN_PAIR) begin
                            o_result.kind         = VK_PAIR;
                            o_result.first_value  = {r_store[1], r_store[0]};
                            o_result.second_value = {r_store[3], r_store[2]};
                        end
                    end
                end
                default: begin
                    o_emit = 1'b0;
                end
            endcase
        end
    end

    // Control and held-field registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR1;
            r_sum   <= '0;
            r_id    <= '0;
            r_len   <= '0;
            r_cmd   <= '0;
            r_seen  <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_sum   <= n_sum;
            r_id    <= n_id;
            r_len   <= n_len;
            r_cmd   <= n_cmd;
            r_seen  <= n_seen;
        end
    end

    // Parameter store, written only for the first kept bytes
    always_ff @(posedge i_clk) begin
        if (i_step && store_we) begin
            r_store[r_seen[IDX_W-1:0]] <= i_rx_byte;
        end
    end

endmodule

// ----- rtl/servo_bus_response_deframer.sv -----
// Servo bus response deframer, top level.
// Channels: i_rx takes one received byte per item (or a line-idle mark),
// o_res gives one item per finished or aborted frame, i_cfg writes the
// header byte that both start bytes must match.
// Path: a byte is registered in the input register, parsed from there
// when the parse stage moves, and its result, if any, is registered in
// the output register that drives o_res.
// Throughput: one byte per cycle while no result is stalled at the output;
// the input register takes a new byte as the held one is parsed.
// Reset (synchronous, active low): the parser hunts for the first header,
// held fields clear, header byte returns to 85, no result is pending.
// Stall: while o_res.ready is low a pending result holds; the byte in the
// input register waits, and i_rx.ready drops once that register is full.
// Header writes are meant for idle periods only; i_cfg is always ready.
// Depends on sbrd_pkg, sbrd_if and sbrd_parser.
module servo_bus_response_deframer #(
    parameter int KEPT_PARAMS = sbrd_pkg::KEPT_PARAMS_DEF
) (
    input logic         i_clk,
    input logic         i_rst_n,
    sbrd_in_if.sink     i_rx,
    sbrd_cfg_if.sink    i_cfg,
    sbrd_out_if.source  o_res
);
    import sbrd_pkg::*;

    t_byte   r_header;
    logic    r_in_valid;
    t_byte   r_in_byte;
    logic    r_in_idle;
    logic    r_out_valid;
    t_result r_out;

    logic    advance;
    logic    step;
    logic    emit;
    t_result result;

    // Pipeline flow: parse stage moves when the output register is free
    assign advance    = !r_out_valid || o_res.ready;
    assign step       = r_in_valid && advance;
    assign i_rx.ready = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    // Header byte register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= HEADER_RESET;
        end else if (i_cfg.valid) begin
            r_header <= i_cfg.header_byte;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
            r_in_idle <= i_rx.line_idle;
        end
    end

    sbrd_parser #(
        .KEPT_PARAMS (KEPT_PARAMS)
    ) u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_rx_byte     (r_in_byte),
        .i_line_idle   (r_in_idle),
        .i_header_byte (r_header),
        .o_emit        (emit),
        .o_result      (result)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && emit) begin
            r_out <= result;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.frame_status = r_out.status;
    assign o_res.unit_id      = r_out.unit_id;
    assign o_res.command      = r_out.command;
    assign o_res.frame_length = r_out.frame_length;
    assign o_res.value_kind   = r_out.kind;
    assign o_res.first_value  = r_out.first_value;
    assign o_res.second_value = r_out.second_value;

endmodule
